// ----- hdl/hid_gamepad_field_mapper_assert.svh -----
// Assertion macros shared by the gamepad field mapper checks.
`ifndef HID_GAMEPAD_FIELD_MAPPER_ASSERT_SVH
`define HID_GAMEPAD_FIELD_MAPPER_ASSERT_SVH

// Same-cycle implication; expects clk and rst_n in scope.
`define HGFM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgfm check failed");

// Next-cycle implication; expects clk and rst_n in scope.
`define HGFM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgfm check failed");

`endif

// ----- hdl/hgfm_pkg.sv -----
// Types, constants and control structs shared by the gamepad field mapper.
package hgfm_pkg;

    localparam int NUM_AXES    = 6;
    localparam int NUM_BUTTONS = 17;

    localparam int IN_TDATA_W  = 136;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 24;

    localparam logic signed [15:0] AXIS_FULL = 16'sd32767;
    localparam logic signed [15:0] AXIS_MIN  = -16'sd32767;

    localparam logic [15:0] PAGE_GENERIC  = 16'h0001;
    localparam logic [15:0] PAGE_BUTTON   = 16'h0009;
    localparam logic [15:0] USAGE_POINTER = 16'h0001;
    localparam logic [15:0] USAGE_X       = 16'h0030;
    localparam logic [15:0] USAGE_Y       = 16'h0031;
    localparam logic [15:0] USAGE_Z       = 16'h0032;
    localparam logic [15:0] USAGE_RZ      = 16'h0035;

    localparam logic [3:0] TRIG_L_FIELD = 4'd8;
    localparam logic [3:0] TRIG_R_FIELD = 4'd9;
    localparam logic [3:0] COUNT_MAX    = 4'd15;

    localparam logic [2:0] AXIS_LX = 3'd0;
    localparam logic [2:0] AXIS_LY = 3'd1;
    localparam logic [2:0] AXIS_RX = 3'd2;
    localparam logic [2:0] AXIS_RY = 3'd3;
    localparam logic [2:0] AXIS_LT = 3'd4;
    localparam logic [2:0] AXIS_RT = 3'd5;

    localparam logic CLASS_AXIS   = 1'b0;
    localparam logic CLASS_BUTTON = 1'b1;

    // |v-min| and |max-min| fit 32 bits; |v-min|*65534 fits 48 bits
    localparam int DIVISOR_W  = 32;
    localparam int DIVIDEND_W = 48;
    localparam int STEP_W     = 6;
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIVIDEND_W - 1);

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic prep;
        logic load;
        logic step;
        logic fix;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic has_result;
        logic needs_div;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- hdl/hid_gamepad_field_mapper.sv -----
// Scaled axis items: accept, decode, prep, load, divide, fix, then emit once the output register is free.
// The divide state runs the 48-step radix-2 divider, one quotient bit per cycle.
// Reads, button fields and flat-range axes go from decode to emit; items with no result return to accept.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst_n low, async): sticks 0, triggers -32767, buttons clear, field count 0.
module hid_gamepad_field_mapper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // page, usage, field_value, logical_min, logical_max, entry_index, zero pad
    input  logic [hgfm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind, entry_class
    input  logic [hgfm_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // target_index, target_value, zero pad
    output logic [hgfm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // target_class
    output logic                                m_tuser
);

    hgfm_pkg::dp_cmd_t  cmd;
    hgfm_pkg::dp_stat_t stat;

    hgfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hgfm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_tdata  (s_tdata),
        .in_tuser  (s_tuser),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_tdata (m_tdata),
        .out_tuser (m_tuser)
    );

endmodule

// ----- hdl/hgfm_div.sv -----
// Radix-2 restoring divider, one quotient bit per step.
module hgfm_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic                             step,
    input  logic [hgfm_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [hgfm_pkg::DIVISOR_W-1:0]   divisor,
    output logic [hgfm_pkg::DIVIDEND_W-1:0]  quotient,
    output logic                             last
);

    logic [hgfm_pkg::DIVIDEND_W-1:0] quo_reg;
    logic [hgfm_pkg::DIVIDEND_W-1:0] quo_next;
    logic [hgfm_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [hgfm_pkg::DIVISOR_W-1:0]  rem_next;
    logic [hgfm_pkg::DIVISOR_W-1:0]  dsr_reg;
    logic [hgfm_pkg::STEP_W-1:0]     cnt_reg;
    logic [hgfm_pkg::DIVISOR_W:0]    shifted;
    logic [hgfm_pkg::DIVISOR_W:0]    trial;
    logic                            fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[hgfm_pkg::DIVIDEND_W-1]};
        trial    = shifted - {1'b0, dsr_reg};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? trial[hgfm_pkg::DIVISOR_W-1:0] : shifted[hgfm_pkg::DIVISOR_W-1:0];
        quo_next = {quo_reg[hgfm_pkg::DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == hgfm_pkg::DIV_LAST);

endmodule

// ----- hdl/hgfm_ctrl.sv -----
// Sequencer for the field mapper: accept, decode, scale, divide, deliver.
module hgfm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hgfm_pkg::dp_stat_t  stat,
    output hgfm_pkg::dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PREP,
        ST_LOAD,
        ST_DIVIDE,
        ST_FIX,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.needs_div)
                begin
                    state_next = ST_PREP;
                end
                else if (stat.has_result)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // wait for the output register to drain
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

// ----- hdl/hgfm_dp.sv -----
// Datapath: item capture, decode, gamepad state, axis scaling and output register.
module hgfm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hgfm_pkg::dp_cmd_t                   cmd,
    output hgfm_pkg::dp_stat_t                  stat,
    input  logic [hgfm_pkg::IN_TDATA_W-1:0]     in_tdata,
    input  logic [hgfm_pkg::IN_TUSER_W-1:0]     in_tuser,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [hgfm_pkg::OUT_TDATA_W-1:0]    out_tdata,
    output logic                                out_tuser
);

    // captured transaction
    logic [1:0]         kind_reg;
    logic [15:0]        page_reg;
    logic [15:0]        usage_reg;
    logic [31:0]        val_reg;
    logic [31:0]        lo_reg;
    logic [31:0]        hi_reg;
    logic               cls_reg;
    logic [4:0]         idx_reg;

    // gamepad state
    logic signed [15:0]                 axis_reg [hgfm_pkg::NUM_AXES];
    logic [hgfm_pkg::NUM_BUTTONS-1:0]   btn_reg;
    logic [3:0]                         count_reg;

    // pending result
    logic               res_cls_reg;
    logic [4:0]         res_idx_reg;
    logic signed [15:0] res_val_reg;
    logic               res_wr_reg;

    // scaling operands
    logic [32:0]                        diff_reg;
    logic [32:0]                        den_reg;
    logic [hgfm_pkg::DIVISOR_W-1:0]     num_mag_reg;
    logic [hgfm_pkg::DIVISOR_W-1:0]     den_mag_reg;
    logic                               neg_reg;
    logic [32:0]                        diff_neg;
    logic [32:0]                        den_neg;
    logic [hgfm_pkg::DIVIDEND_W-1:0]    dividend;
    logic [hgfm_pkg::DIVIDEND_W-1:0]    quotient;
    logic                               div_last;
    logic [16:0]                        q_off;
    logic signed [15:0]                 fix_val;

    // output register
    logic                               out_valid_reg;
    logic [hgfm_pkg::OUT_TDATA_W-1:0]   out_tdata_reg;
    logic                               out_tuser_reg;

    // decode
    logic               is_gd;
    logic               is_count_field;
    logic               trig_hit;
    logic [2:0]         trig_axis;
    logic               stick_hit;
    logic [2:0]         stick_axis;
    logic               btn_hit;
    logic               bounds_eq;
    logic               axis_rd_ok;
    logic               btn_rd_ok;
    logic               dec_has;
    logic               dec_div;
    logic               dec_wr;
    logic               dec_cls;
    logic [4:0]         dec_idx;
    logic signed [15:0] dec_val;

    assign is_gd          = (page_reg == hgfm_pkg::PAGE_GENERIC);
    assign is_count_field = is_gd && (usage_reg == hgfm_pkg::USAGE_POINTER);
    assign trig_hit       = is_count_field && ((count_reg == hgfm_pkg::TRIG_L_FIELD) ||
                                               (count_reg == hgfm_pkg::TRIG_R_FIELD));
    assign trig_axis      = (count_reg == hgfm_pkg::TRIG_L_FIELD) ? hgfm_pkg::AXIS_LT
                                                                  : hgfm_pkg::AXIS_RT;
    // buttons 9 and 10 are the trigger usages and are skipped
    assign btn_hit        = (page_reg == hgfm_pkg::PAGE_BUTTON) &&
                            (usage_reg inside {[16'd1:16'd8], [16'd11:16'd17]});
    assign bounds_eq      = (lo_reg == hi_reg);
    assign axis_rd_ok     = (idx_reg < 5'(hgfm_pkg::NUM_AXES));
    assign btn_rd_ok      = (idx_reg < 5'(hgfm_pkg::NUM_BUTTONS));

    always_comb
    begin
        stick_hit  = is_gd;
        stick_axis = hgfm_pkg::AXIS_LX;
        case (usage_reg)
            hgfm_pkg::USAGE_X:  stick_axis = hgfm_pkg::AXIS_LX;
            hgfm_pkg::USAGE_Y:  stick_axis = hgfm_pkg::AXIS_LY;
            hgfm_pkg::USAGE_Z:  stick_axis = hgfm_pkg::AXIS_RX;
            hgfm_pkg::USAGE_RZ: stick_axis = hgfm_pkg::AXIS_RY;
            default:            stick_hit  = 1'b0;
        endcase
    end

    always_comb
    begin
        dec_has = 1'b0;
        dec_div = 1'b0;
        dec_wr  = 1'b0;
        dec_cls = hgfm_pkg::CLASS_AXIS;
        dec_idx = '0;
        dec_val = '0;
        case (kind_reg)
            hgfm_pkg::KIND_READ:
            begin
                dec_cls = cls_reg;
                dec_idx = idx_reg;
                if (cls_reg == hgfm_pkg::CLASS_AXIS)
                begin
                    dec_has = axis_rd_ok;
                    dec_val = axis_reg[idx_reg[2:0]];
                end
                else
                begin
                    dec_has = btn_rd_ok;
                    dec_val = {15'd0, btn_reg[idx_reg]};
                end
            end
            hgfm_pkg::KIND_FIELD:
            begin
                if (trig_hit || stick_hit)
                begin
                    dec_has = 1'b1;
                    dec_wr  = 1'b1;
                    dec_div = !bounds_eq;
                    dec_idx = trig_hit ? 5'(trig_axis) : 5'(stick_axis);
                    // flat range: sticks center, triggers rest
                    dec_val = trig_hit ? hgfm_pkg::AXIS_MIN : 16'sd0;
                end
                else if (btn_hit)
                begin
                    dec_has = 1'b1;
                    dec_wr  = 1'b1;
                    dec_cls = hgfm_pkg::CLASS_BUTTON;
                    dec_idx = usage_reg[4:0] - 5'd1;
                    dec_val = {15'd0, (val_reg != 32'd0)};
                end
            end
            default:
            begin
                dec_has = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= in_tuser[1:0];
            cls_reg   <= in_tuser[2];
            page_reg  <= in_tdata[15:0];
            usage_reg <= in_tdata[31:16];
            val_reg   <= in_tdata[63:32];
            lo_reg    <= in_tdata[95:64];
            hi_reg    <= in_tdata[127:96];
            idx_reg   <= in_tdata[132:128];
        end
    end

    // scaling: |v-min|*65534 / |max-min|, sign handled at the end
    assign diff_neg = -diff_reg;
    assign den_neg  = -den_reg;
    assign dividend = {num_mag_reg, 16'd0} - {15'd0, num_mag_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            res_cls_reg <= dec_cls;
            res_idx_reg <= dec_idx;
            res_val_reg <= dec_val;
            res_wr_reg  <= dec_wr;
            diff_reg    <= {val_reg[31], val_reg} - {lo_reg[31], lo_reg};
            den_reg     <= {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg};
        end
        if (cmd.prep)
        begin
            num_mag_reg <= diff_reg[32] ? diff_neg[31:0] : diff_reg[31:0];
            den_mag_reg <= den_reg[32] ? den_neg[31:0] : den_reg[31:0];
            neg_reg     <= diff_reg[32] ^ den_reg[32];
        end
        if (cmd.fix)
        begin
            res_val_reg <= fix_val;
        end
    end

    hgfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.load),
        .step     (cmd.step),
        .dividend (dividend),
        .divisor  (den_mag_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    // a negative quotient always lands at or below the floor
    always_comb
    begin
        q_off = {1'b0, quotient[15:0]} - 17'(hgfm_pkg::AXIS_FULL);
        if (neg_reg)
        begin
            fix_val = hgfm_pkg::AXIS_MIN;
        end
        else if ((|quotient[hgfm_pkg::DIVIDEND_W-1:16]) || (&quotient[15:0]))
        begin
            fix_val = hgfm_pkg::AXIS_FULL;
        end
        else
        begin
            fix_val = q_off[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hgfm_pkg::NUM_AXES; i++)
            begin
                axis_reg[i] <= ((i == int'(hgfm_pkg::AXIS_LT)) ||
                                (i == int'(hgfm_pkg::AXIS_RT))) ? hgfm_pkg::AXIS_MIN
                                                                : 16'sd0;
            end
            btn_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.decode)
            begin
                if (kind_reg == hgfm_pkg::KIND_START)
                begin
                    count_reg <= '0;
                end
                else if ((kind_reg == hgfm_pkg::KIND_FIELD) && is_count_field &&
                         (count_reg != hgfm_pkg::COUNT_MAX))
                begin
                    count_reg <= count_reg + 4'd1;
                end
            end
            if (cmd.emit && res_wr_reg)
            begin
                if (res_cls_reg == hgfm_pkg::CLASS_AXIS)
                begin
                    axis_reg[res_idx_reg[2:0]] <= res_val_reg;
                end
                else
                begin
                    btn_reg[res_idx_reg] <= res_val_reg[0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_tdata_reg <= {3'd0, res_val_reg, res_idx_reg};
            out_tuser_reg <= res_cls_reg;
        end
    end

    assign stat.has_result = dec_has;
    assign stat.needs_div  = dec_div;
    assign stat.div_last   = div_last;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_tdata = out_tdata_reg;
    assign out_tuser = out_tuser_reg;

endmodule

// ----- hdl/hgfm_checker.sv -----
// Port-level checks for the gamepad field mapper, bound to the top level.
`include "hid_gamepad_field_mapper_assert.svh"

module hgfm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [hgfm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tuser
);

    // a stalled result holds
    `HGFM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one transaction in flight at a time
    `HGFM_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

    // axis results are saturated and address a real axis
    `HGFM_ASSERT_NOW(a_axis_range, m_tvalid && !m_tuser, (m_tdata[20:5] != 16'h8000) && (m_tdata[4:0] < 5'd6))

    // button results carry a single bit
    `HGFM_ASSERT_NOW(a_button_bit, m_tvalid && m_tuser, (m_tdata[20:6] == 15'd0) && (m_tdata[4:0] < 5'd17))

endmodule

bind hid_gamepad_field_mapper hgfm_checker u_hgfm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
